// ----- rtl/core/i2c_bm_pkg.sv -----
// Package for the I2C bit-level master.
// Holds the command opcodes, the reset hold time and the pin-write type.
// No dependencies.
package i2c_bm_pkg;

  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_STOP  = 3'd1;
  localparam logic [2:0] OP_SEND  = 3'd2;
  localparam logic [2:0] OP_RECV  = 3'd3;
  localparam logic [2:0] OP_SACK  = 3'd4;
  localparam logic [2:0] OP_RACK  = 3'd5;

  localparam logic [15:0] HOLD_RESET = 16'd500;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       last;
    logic [7:0] rx;
    logic       ack;
  } pin_wr_t;

endpackage

// ----- rtl/core/i2c_bm_if.sv -----
// Channel interfaces of the I2C bit-level master: command, result and
// configuration. Each carries valid, ready and its payload.
// No dependencies.
interface i2c_bm_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] tx_byte;
  logic       ack_to_send;
  logic [7:0] slave_sda_bits;
  logic       slave_ack;

  modport source (output valid, opcode, tx_byte, ack_to_send, slave_sda_bits, slave_ack,
                  input ready);
  modport sink (input valid, opcode, tx_byte, ack_to_send, slave_sda_bits, slave_ack,
                output ready);
endinterface

interface i2c_bm_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       last_write;
  logic [7:0] rx_byte;
  logic       ack_seen;

  modport source (output valid, scl_level, sda_level, last_write, rx_byte, ack_seen,
                  input ready);
  modport sink (input valid, scl_level, sda_level, last_write, rx_byte, ack_seen,
                output ready);
endinterface

interface i2c_bm_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- rtl/core/i2c_bit_level_master.sv -----
// Top level of the I2C bit-level master: sequencer, hold counter and the
// result register. Depends on i2c_bm_pkg, i2c_bm_if, i2c_bm_hold, i2c_bm_seq.
//
// Each command item is one bus primitive and produces one result item per
// pin write: start 4, stop 3, send byte 24, receive byte 17, send ack 3,
// receive ack 3; opcodes 6 and 7 are taken and produce nothing. After every
// pin write the hold counter loads hold_cycles and counts down to zero (reset 500,
// a write of 0 counts as 1). The next pin write waits for that hold to run
// out, and also for room in the result register while the consumer stalls.
// The next command is taken once the hold after the last write has run out.
module i2c_bit_level_master import i2c_bm_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  i2c_bm_cmd_if.sink    cmd,
  i2c_bm_res_if.source  res,
  i2c_bm_cfg_if.sink    cfg
);

  pin_wr_t wr;
  logic    wr_valid;
  logic    wr_free;
  logic    hold_start;
  logic    hold_busy;

  i2c_bm_hold u_hold (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .start (hold_start),
    .busy  (hold_busy)
  );

  i2c_bm_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .wr_valid   (wr_valid),
    .wr_free    (wr_free),
    .wr         (wr),
    .hold_start (hold_start),
    .hold_busy  (hold_busy)
  );

  assign wr_free = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (wr_valid && wr_free) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid && wr_free) begin
      res.scl_level  <= wr.scl;
      res.sda_level  <= wr.sda;
      res.last_write <= wr.last;
      res.rx_byte    <= wr.rx;
      res.ack_seen   <= wr.ack;
    end
  end

`ifndef SYNTH
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |=> (res.valid && $stable(res.last_write)))
    else $error("Result item changed while stalled.");
  a_rx_only_last: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.last_write) |-> ((res.rx_byte == 8'd0) && !res.ack_seen))
    else $error("Received data shown before the last write.");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (wr_valid && !wr_free) |=> res.valid)
    else $error("Result register dropped an item.");
`endif

endmodule

// ----- rtl/core/i2c_bm_hold.sv -----
// Hold-time register and down counter of the I2C bit-level master.
// Depends on i2c_bm_pkg and the configuration interface in i2c_bm_if.
module i2c_bm_hold import i2c_bm_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  i2c_bm_cfg_if.sink    cfg,
  input  logic          start,
  output logic          busy
);

  logic [15:0] hold_cycles;
  logic [15:0] cnt;

  assign cfg.ready = 1'b1;
  assign busy = (cnt != 16'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_cycles <= HOLD_RESET;
    end else if (cfg.valid) begin
      hold_cycles <= (cfg.data == 16'd0) ? 16'd1 : cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 16'd0;
    end else if (start) begin
      cnt <= hold_cycles;
    end else if (busy) begin
      cnt <= cnt - 16'd1;
    end
  end

endmodule

// ----- rtl/core/i2c_bm_seq.sv -----
// Command sequencer of the I2C bit-level master: steps through the pin
// writes of one command and shifts data bits in and out, one per SCL pulse.
// Depends on i2c_bm_pkg and the command interface in i2c_bm_if.
module i2c_bm_seq import i2c_bm_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  i2c_bm_cmd_if.sink    cmd,
  output logic          wr_valid,
  input  logic          wr_free,
  output pin_wr_t       wr,
  output logic          hold_start,
  input  logic          hold_busy
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_HOLD  = 2'd2;

  logic [1:0] state;
  logic [2:0] op;
  logic [1:0] phase;
  logic [2:0] bitn;
  logic [7:0] tx_sh;
  logic [7:0] slv_sh;
  logic [7:0] rx_sh;
  logic       ackv;
  logic       slack;
  logic       ack_q;
  logic       scl_out;
  logic       sda_out;
  logic       last_q;

  logic       is_scl;
  logic       val;
  logic       last;
  logic       sample;
  logic       shift_tx;
  logic [1:0] phase_next;
  logic [2:0] bitn_next;
  logic       wr_fire;
  logic       cmd_fire;

  always_comb begin
    is_scl     = 1'b0;
    val        = 1'b1;
    last       = 1'b0;
    sample     = 1'b0;
    shift_tx   = 1'b0;
    phase_next = phase + 2'd1;
    bitn_next  = bitn;
    unique case (op)
      OP_START: begin
        is_scl = phase[0];
        val    = ~phase[1];
        last   = (phase == 2'd3);
      end
      OP_STOP: begin
        is_scl = (phase == 2'd1);
        val    = (phase != 2'd0);
        last   = (phase == 2'd2);
      end
      OP_SEND: begin
        unique case (phase)
          2'd0: begin
            val = tx_sh[7];
          end
          2'd1: begin
            is_scl = 1'b1;
          end
          default: begin
            is_scl     = 1'b1;
            val        = 1'b0;
            shift_tx   = 1'b1;
            phase_next = 2'd0;
            bitn_next  = bitn + 3'd1;
            last       = (bitn == 3'd7);
          end
        endcase
      end
      OP_RECV: begin
        unique case (phase)
          2'd0: begin
            val = 1'b1;
          end
          2'd1: begin
            is_scl = 1'b1;
            sample = 1'b1;
          end
          default: begin
            is_scl = 1'b1;
            val    = 1'b0;
            if (bitn == 3'd7) begin
              last = 1'b1;
            end else begin
              phase_next = 2'd1;
              bitn_next  = bitn + 3'd1;
            end
          end
        endcase
      end
      OP_SACK, OP_RACK: begin
        unique case (phase)
          2'd0: begin
            val = (op == OP_SACK) ? ackv : 1'b1;
          end
          2'd1: begin
            is_scl = 1'b1;
            sample = 1'b1;
          end
          default: begin
            is_scl = 1'b1;
            val    = 1'b0;
            last   = 1'b1;
          end
        endcase
      end
      default: begin
        last = 1'b1;
      end
    endcase
  end

  assign cmd.ready  = (state == S_IDLE);
  assign cmd_fire   = cmd.valid && cmd.ready;
  assign wr_valid   = (state == S_ISSUE);
  assign wr_fire    = wr_valid && wr_free;
  assign hold_start = wr_fire;

  assign wr.scl  = is_scl ? val : scl_out;
  assign wr.sda  = is_scl ? sda_out : val;
  assign wr.last = last;
  assign wr.rx   = (last && (op == OP_RECV)) ? rx_sh : 8'd0;
  assign wr.ack  = last && (op == OP_RACK) && ack_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      scl_out <= 1'b1;
      sda_out <= 1'b1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_fire && (cmd.opcode <= OP_RACK)) begin
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (wr_fire) begin
            state   <= S_HOLD;
            scl_out <= wr.scl;
            sda_out <= wr.sda;
          end
        end
        S_HOLD: begin
          if (!hold_busy) begin
            state <= last_q ? S_IDLE : S_ISSUE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      op     <= cmd.opcode;
      phase  <= 2'd0;
      bitn   <= 3'd0;
      tx_sh  <= cmd.tx_byte;
      slv_sh <= cmd.slave_sda_bits;
      rx_sh  <= 8'd0;
      ackv   <= cmd.ack_to_send;
      slack  <= cmd.slave_ack;
      ack_q  <= 1'b0;
      last_q <= 1'b0;
    end else if (wr_fire) begin
      phase  <= phase_next;
      bitn   <= bitn_next;
      last_q <= last;
      if (shift_tx) begin
        tx_sh <= {tx_sh[6:0], 1'b0};
      end
      if (sample) begin
        rx_sh  <= {rx_sh[6:0], slv_sh[7]};
        slv_sh <= {slv_sh[6:0], 1'b0};
        ack_q  <= slack;
      end
    end
  end

`ifndef SYNTH
  a_issue_after_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_ISSUE) |-> !hold_busy)
    else $error("Pin write pending while the hold counter runs.");
  a_hold_after_write: assert property (@(posedge clk) disable iff (rst)
    wr_fire |=> ((state == S_HOLD) && hold_busy))
    else $error("No hold time after a pin write.");
  a_start_leaves_low: assert property (@(posedge clk) disable iff (rst)
    (wr_fire && last && (op == OP_START)) |=> (!scl_out && !sda_out))
    else $error("Start did not leave both lines low.");
  a_stop_leaves_high: assert property (@(posedge clk) disable iff (rst)
    (wr_fire && last && (op == OP_STOP)) |=> (scl_out && sda_out))
    else $error("Stop did not leave both lines released.");
`endif

endmodule

// ----- bench/i2c_bit_level_master_tb.sv -----
// Testbench for the I2C bit-level master: drives bus primitives, predicts every pin write
// and checks each result item in order against that prediction.
// Depends on i2c_bm_pkg, the i2c_bm interfaces and i2c_bit_level_master.
module i2c_bit_level_master_tb;
  import i2c_bm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_UNUSED_LO = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam int         MAX_REPORTS  = 10;
  localparam int         HOLD_OFF_LEN = 3000;

  class bus_wave_board;
    pin_wr_t pending_writes[$];
    bit      scl_now = 1'b1;
    bit      sda_now = 1'b1;
    int      fault_count = 0;

    function void drive_pin(bit is_scl, bit level);
      pin_wr_t w;
      if (is_scl) scl_now = level;
      else sda_now = level;
      w.scl  = scl_now;
      w.sda  = sda_now;
      w.last = 1'b0;
      w.rx   = 8'h00;
      w.ack  = 1'b0;
      pending_writes.push_back(w);
    endfunction

    function void predict_writes(logic [2:0] op, logic [7:0] tx, logic ackv,
                                 logic [7:0] slv, logic slack);
      pin_wr_t    w;
      logic [7:0] rx;
      logic       ack;
      rx  = 8'h00;
      ack = 1'b0;
      case (op)
        OP_START: begin
          drive_pin(0, 1); drive_pin(1, 1); drive_pin(0, 0); drive_pin(1, 0);
        end
        OP_STOP: begin
          drive_pin(0, 0); drive_pin(1, 1); drive_pin(0, 1);
        end
        OP_SEND: begin
          for (int i = 7; i >= 0; i--) begin
            drive_pin(0, tx[i]); drive_pin(1, 1); drive_pin(1, 0);
          end
        end
        OP_RECV: begin
          drive_pin(0, 1);
          for (int i = 7; i >= 0; i--) begin
            drive_pin(1, 1);
            rx[i] = slv[i];
            drive_pin(1, 0);
          end
        end
        OP_SACK: begin
          drive_pin(0, ackv); drive_pin(1, 1); drive_pin(1, 0);
        end
        OP_RACK: begin
          drive_pin(0, 1); drive_pin(1, 1); drive_pin(1, 0);
          ack = slack;
        end
        default: return;
      endcase
      w      = pending_writes.pop_back();
      w.last = 1'b1;
      w.rx   = rx;
      w.ack  = ack;
      pending_writes.push_back(w);
    endfunction

    function void check_write(pin_wr_t got);
      pin_wr_t exp;
      if (pending_writes.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("unexpected item: scl=%0b sda=%0b last=%0b rx=%02h ack=%0b",
                   got.scl, got.sda, got.last, got.rx, got.ack);
        return;
      end
      exp = pending_writes.pop_front();
      if (got.scl !== exp.scl || got.sda !== exp.sda || got.last !== exp.last ||
          got.rx !== exp.rx || got.ack !== exp.ack) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display({"mismatch: expected scl=%0b sda=%0b last=%0b rx=%02h ack=%0b,",
                    " got scl=%0b sda=%0b last=%0b rx=%02h ack=%0b"},
                   exp.scl, exp.sda, exp.last, exp.rx, exp.ack,
                   got.scl, got.sda, got.last, got.rx, got.ack);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  i2c_bm_cmd_if cmd_ch ();
  i2c_bm_res_if res_ch ();
  i2c_bm_cfg_if cfg_ch ();

  i2c_bit_level_master dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  bus_wave_board board;
  int            hold_now = int'(HOLD_RESET);
  bit            hold_off_req = 1'b0;
  int            send_calm = 0;
  int            recv_calm = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #8ms;
    $display("i2c_bit_level_master_tb NOT OK");
    $finish;
  end

  function automatic int pick_gap(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(10, 40);
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic drive_cmd(logic [2:0] op, logic [7:0] tx, logic ackv,
                           logic [7:0] slv, logic slack);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid          <= 1'b1;
    cmd_ch.opcode         <= op;
    cmd_ch.tx_byte        <= tx;
    cmd_ch.ack_to_send    <= ackv;
    cmd_ch.slave_sda_bits <= slv;
    cmd_ch.slave_ack      <= slack;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    board.predict_writes(op, tx, ackv, slv, slack);
  endtask

  task automatic send_op(logic [2:0] op);
    drive_cmd(op, 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic settle();
    cmd_ch.valid <= 1'b0;
    while (board.pending_writes.size() != 0) @(posedge clk);
    repeat (hold_now + 8) @(posedge clk);
  endtask

  task automatic set_hold(logic [15:0] value);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    hold_now = (value == 16'd0) ? 1 : int'(value);
  endtask

  task automatic run_random(int target);
    int count;
    int r;
    int k;
    logic [2:0] op;
    count = 0;
    while (count < target) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        send_op(OP_START);
        send_op(OP_SEND);
        send_op(OP_RACK);
        count += 3;
        k = $urandom_range(0, 3);
        for (int i = 0; i < k; i++) begin
          if ($urandom_range(0, 1) == 1) begin
            send_op(OP_RECV);
            send_op(OP_SACK);
          end else begin
            send_op(OP_SEND);
            send_op(OP_RACK);
          end
          count += 2;
        end
        if ($urandom_range(0, 9) != 0) begin
          send_op(OP_STOP);
          count++;
        end
      end else begin
        op = 3'($urandom_range(0, 7));
        send_op(op);
        if (op != OP_UNUSED_LO && op != OP_UNUSED_HI) count++;
      end
    end
  endtask

  initial begin
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      int gap;
      if (hold_off_req) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_OFF_LEN) @(posedge clk);
        hold_off_req = 1'b0;
      end
      gap = pick_gap(recv_calm);
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    pin_wr_t got;
    if (rst === 1'b0 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      got.scl  = res_ch.scl_level;
      got.sda  = res_ch.sda_level;
      got.last = res_ch.last_write;
      got.rx   = res_ch.rx_byte;
      got.ack  = res_ch.ack_seen;
      board.check_write(got);
    end
  end

  initial begin
    board = new();
    rst                   <= 1'b1;
    cmd_ch.valid          <= 1'b0;
    cmd_ch.opcode         <= OP_START;
    cmd_ch.tx_byte        <= 8'h00;
    cmd_ch.ack_to_send    <= 1'b0;
    cmd_ch.slave_sda_bits <= 8'h00;
    cmd_ch.slave_ack      <= 1'b0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.data           <= 16'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    drive_cmd(OP_START, 8'h00, 1'b0, 8'h00, 1'b0);
    drive_cmd(OP_SEND,  8'hA5, 1'b0, 8'h00, 1'b0);
    drive_cmd(OP_RACK,  8'h00, 1'b0, 8'h00, 1'b0);
    drive_cmd(OP_RECV,  8'h00, 1'b0, 8'h3C, 1'b0);
    drive_cmd(OP_SACK,  8'h00, 1'b1, 8'h00, 1'b0);
    drive_cmd(OP_STOP,  8'h00, 1'b0, 8'h00, 1'b0);

    set_hold(16'd0);
    drive_cmd(OP_START,      8'hFF, 1'b1, 8'hFF, 1'b1);
    drive_cmd(OP_SEND,       8'h00, 1'b1, 8'hFF, 1'b1);
    drive_cmd(OP_SEND,       8'hFF, 1'b0, 8'h00, 1'b0);
    drive_cmd(OP_SEND,       8'h80, 1'b0, 8'h00, 1'b0);
    drive_cmd(OP_SEND,       8'h01, 1'b0, 8'h00, 1'b0);
    drive_cmd(OP_RACK,       8'hFF, 1'b0, 8'hFF, 1'b1);
    drive_cmd(OP_RACK,       8'h00, 1'b1, 8'h00, 1'b0);
    drive_cmd(OP_UNUSED_LO,  8'hFF, 1'b1, 8'hFF, 1'b1);
    drive_cmd(OP_RECV,       8'hFF, 1'b1, 8'h00, 1'b1);
    drive_cmd(OP_RECV,       8'h00, 1'b0, 8'hFF, 1'b0);
    drive_cmd(OP_RECV,       8'h00, 1'b0, 8'h80, 1'b0);
    drive_cmd(OP_RECV,       8'h00, 1'b0, 8'h01, 1'b0);
    drive_cmd(OP_SACK,       8'h00, 1'b0, 8'h00, 1'b1);
    drive_cmd(OP_SACK,       8'hFF, 1'b1, 8'hFF, 1'b0);
    drive_cmd(OP_START,      8'h00, 1'b0, 8'h00, 1'b0);
    drive_cmd(OP_UNUSED_HI,  8'h00, 1'b0, 8'h00, 1'b0);
    drive_cmd(OP_STOP,       8'h00, 1'b0, 8'h00, 1'b0);
    drive_cmd(OP_STOP,       8'hFF, 1'b1, 8'hFF, 1'b1);

    set_hold(16'hFFFF);
    drive_cmd(OP_STOP, 8'h00, 1'b0, 8'h00, 1'b0);

    set_hold(16'd1);
    hold_off_req = 1'b1;
    run_random(25);

    set_hold(16'($urandom_range(2, 24)));
    run_random(25);

    set_hold(16'($urandom_range(1, 6)));
    run_random(20);

    settle();
    repeat (20) @(posedge clk);
    if (board.fault_count == 0 && board.pending_writes.size() == 0) begin
      $display("i2c_bit_level_master_tb OK");
    end else begin
      $display("i2c_bit_level_master_tb NOT OK");
    end
    $finish;
  end

endmodule
